// ===== rtl/fru_pkg.sv =====
// Shared types and constants of the fraction reduce unit.
package fru_pkg;

  // Width of the signed numerator and denominator.
  localparam int unsigned VALUE_WIDTH = 32;
  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One fraction as it arrives.
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] numerator;
    logic signed [VALUE_WIDTH-1:0] denominator;
  } in_item_t;

  // One reduced fraction as it leaves.
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] reduced_numerator;
    logic        [VALUE_WIDTH-2:0] reduced_denominator;
    logic                          zero_denominator;
  } out_item_t;

  // Classified fraction: magnitudes, sign of the quotient, zero flag.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] mag_num;
    logic [VALUE_WIDTH-1:0] mag_den;
    logic                   negative;
    logic                   zero_den;
  } work_item_t;

endpackage

// ===== rtl/fru_front.sv =====
// Front end: accepts fractions, splits off signs and flags a zero denominator.
module fru_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  fru_pkg::in_item_t  in_item,
  output logic               q_push,
  input  logic               q_full,
  output fru_pkg::work_item_t q_item
);
  import fru_pkg::*;

  logic       fr_valid_r, fr_valid_nxt;
  work_item_t fr_item_r;
  work_item_t cls_item;
  logic       accept;
  logic       num_neg, den_neg;

  // Classify the incoming item
  always_comb begin
    num_neg           = in_item.numerator[VALUE_WIDTH-1];
    den_neg           = in_item.denominator[VALUE_WIDTH-1];
    cls_item.mag_num  = num_neg ? (~in_item.numerator + 1'b1) : in_item.numerator;
    cls_item.mag_den  = den_neg ? (~in_item.denominator + 1'b1) : in_item.denominator;
    cls_item.negative = num_neg ^ den_neg;
    cls_item.zero_den = (in_item.denominator == '0);
  end

  // Hold the classified item until the queue takes it
  assign q_push  = fr_valid_r && !q_full;
  assign q_item  = fr_item_r;
  assign in_full = fr_valid_r && q_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    if (accept) begin
      fr_item_r <= cls_item;
    end
  end

endmodule

// ===== rtl/fru_queue.sv =====
// Short queue of classified items between front and back.
module fru_queue #(
  parameter int unsigned DEPTH = fru_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  fru_pkg::work_item_t push_item,
  input  logic                pop,
  output logic                empty,
  output fru_pkg::work_item_t pop_item
);
  import fru_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_item_t       slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/fru_back.sv =====
// Back end: binary GCD, two serial divisions and sign placement.
module fru_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  fru_pkg::work_item_t q_item,
  output logic                out_empty,
  input  logic                out_pop,
  output fru_pkg::out_item_t  out_item
);
  import fru_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned KW   = $clog2(W);
  localparam int unsigned CW   = $clog2(W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t         state_r, state_nxt;
  logic [W-1:0]   a_r, a_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [W-1:0]   g_r, g_nxt;
  logic [W-1:0]   nq_r, nq_nxt;
  logic [W-1:0]   dq_r, dq_nxt;
  logic [W-1:0]   nrem_r, nrem_nxt;
  logic [W-1:0]   drem_r, drem_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           neg_r, neg_nxt;
  logic           zero_r, zero_nxt;
  logic           ov_r, ov_nxt;
  out_item_t      res_r, res_nxt;

  logic [W:0]     diff_ab, diff_ba;
  logic [W:0]     ntrial, dtrial;
  logic [W:0]     ntrial_sub, dtrial_sub;
  logic [W-1:0]   sat_half;
  logic [W-1:0]   neg_qn;
  out_item_t      fin_item;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_empty = !ov_r;
  assign out_item  = res_r;
  assign sat_half  = {1'b0, {(W-1){1'b1}}};

  // Subtractors of the GCD step and trial subtractions of both dividers
  always_comb begin
    diff_ab    = {1'b0, a_r} - {1'b0, b_r};
    diff_ba    = {1'b0, b_r} - {1'b0, a_r};
    ntrial     = {nrem_r, nq_r[W-1]};
    dtrial     = {drem_r, dq_r[W-1]};
    ntrial_sub = ntrial - {1'b0, g_r};
    dtrial_sub = dtrial - {1'b0, g_r};
  end

  // Build the result: saturate, put the sign on the numerator, and give 0/0 on a zero denominator
  always_comb begin
    neg_qn = ~nq_r + 1'b1;
    fin_item.zero_denominator    = zero_r;
    fin_item.reduced_denominator = dq_r[W-1] ? sat_half[W-2:0] : dq_r[W-2:0];
    if (nq_r != '0 && neg_r) begin
      fin_item.reduced_numerator = neg_qn;
    end else begin
      fin_item.reduced_numerator = nq_r[W-1] ? sat_half : nq_r;
    end
    if (zero_r) begin
      fin_item.reduced_numerator   = '0;
      fin_item.reduced_denominator = '0;
    end
  end

  // Sequence one item through GCD and division
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    g_nxt     = g_r;
    nq_nxt    = nq_r;
    dq_nxt    = dq_r;
    nrem_nxt  = nrem_r;
    drem_nxt  = drem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    ov_nxt    = ov_r;
    res_nxt   = res_r;

    // drop the result once taken
    if (ov_r && out_pop) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          a_nxt    = q_item.mag_num;
          b_nxt    = q_item.mag_den;
          nq_nxt   = q_item.mag_num;
          dq_nxt   = q_item.mag_den;
          k_nxt    = '0;
          neg_nxt  = q_item.negative;
          zero_nxt = q_item.zero_den;
          state_nxt = q_item.zero_den ? ST_FIN : ST_GCD;
        end
      end
      ST_GCD: begin
        if (a_r == '0) begin
          g_nxt     = b_r << k_r;
          nrem_nxt  = '0;
          drem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else if (b_r == '0) begin
          g_nxt     = a_r << k_r;
          nrem_nxt  = '0;
          drem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (!diff_ab[W]) begin
          a_nxt = {1'b0, diff_ab[W-1:1]};
        end else begin
          b_nxt = {1'b0, diff_ba[W-1:1]};
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle for both magnitudes
        if (!ntrial_sub[W]) begin
          nrem_nxt = ntrial_sub[W-1:0];
          nq_nxt   = {nq_r[W-2:0], 1'b1};
        end else begin
          nrem_nxt = ntrial[W-1:0];
          nq_nxt   = {nq_r[W-2:0], 1'b0};
        end
        if (!dtrial_sub[W]) begin
          drem_nxt = dtrial_sub[W-1:0];
          dq_nxt   = {dq_r[W-2:0], 1'b1};
        end else begin
          drem_nxt = dtrial[W-1:0];
          dq_nxt   = {dq_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ov_r || out_pop) begin
          res_nxt   = fin_item;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    k_r    <= k_nxt;
    g_r    <= g_nxt;
    nq_r   <= nq_nxt;
    dq_r   <= dq_nxt;
    nrem_r <= nrem_nxt;
    drem_r <= drem_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== rtl/fraction_reduce_unit.sv =====
// Top level of the fraction reduce unit.
// Reduces a signed fraction to lowest terms: the greatest common divisor of
// the two magnitudes is found with a binary GCD (one shift or subtract-and-
// shift per cycle), then both magnitudes are divided by it in two restoring
// dividers side by side, one quotient bit per cycle. The sign goes on the
// numerator; the denominator is never negative. A zero denominator raises
// zero_denominator and gives 0/0 without the GCD loop or the dividers. In the
// back end an item is loaded, goes through the GCD loop and the dividers, and
// its result is written to the output register; before that it sits in the
// front register. The front end and a QUEUE_DEPTH entry queue keep taking
// items while the back end works and while a finished result waits to be
// popped, until the queue and the front register are full.
module fraction_reduce_unit #(
  parameter int unsigned QUEUE_DEPTH = fru_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  fru_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output fru_pkg::out_item_t out_item
);
  import fru_pkg::*;

  logic       q_push, q_full, q_pop, q_empty;
  work_item_t q_wr_item, q_rd_item;

  fru_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_item  (q_wr_item)
  );

  fru_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .full      (q_full),
    .push_item (q_wr_item),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_rd_item)
  );

  fru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_rd_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== verif/fraction_reduce_unit_tb.sv =====
// Testbench for fraction_reduce_unit: directed and random fractions against a lowest-terms predictor.
module fraction_reduce_unit_tb;
  import fru_pkg::*;

  localparam int VW = fru_pkg::VALUE_WIDTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  // Reduced fractions still owed by the block, oldest first
  out_item_t reduced_q[$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      hold_req = 1'b0;
  logic      hold_ack = 1'b0;
  int        hold_left = 0;

  fraction_reduce_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fraction_reduce_unit test failed");
      $finish;
    end
  end

  // Reduce a fraction to lowest terms, sign on the numerator
  function automatic out_item_t reduce_fraction(in_item_t it);
    logic [VW-1:0] mag_n, mag_d, x, y, r, g, qn, qd, half;
    logic          neg;
    out_item_t     res;
    half  = {1'b0, {(VW-1){1'b1}}};
    mag_n = it.numerator[VW-1] ? (~it.numerator + 1'b1) : it.numerator;
    mag_d = it.denominator[VW-1] ? (~it.denominator + 1'b1) : it.denominator;
    neg   = it.numerator[VW-1] ^ it.denominator[VW-1];
    res   = '0;
    if (mag_d == '0) begin
      res.zero_denominator = 1'b1;
      return res;
    end
    // Euclid on the magnitudes
    x = mag_n;
    y = mag_d;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    g  = x;
    qn = mag_n / g;
    qd = mag_d / g;
    if (qd > half) qd = half;
    if (qn != '0 && neg) begin
      res.reduced_numerator = ~qn + 1'b1;
    end else begin
      if (qn > half) qn = half;
      res.reduced_numerator = qn;
    end
    res.reduced_denominator = qd[VW-2:0];
    return res;
  endfunction

  // Offer one item after a random gap; log its reduced form once taken
  task automatic push_fraction(input logic [VW-1:0] num, input logic [VW-1:0] den);
    in_item_t it;
    it.numerator   = num;
    it.denominator = den;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    reduced_q.push_back(reduce_fraction(it));
  endtask

  // Full-range value without the most negative code
  function automatic logic [VW-1:0] any_value();
    logic [VW-1:0] v;
    v = $urandom;
    if (v == {1'b1, {(VW-1){1'b0}}}) v = v + 1'b1;
    return v;
  endfunction

  function automatic logic [VW-1:0] signed_small(input int unsigned mag);
    logic [VW-1:0] v;
    v = mag;
    if ($urandom_range(1)) v = ~v + 1'b1;
    return v;
  endfunction

  // Drive the pop side: random idling plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop   <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_pop   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each popped item with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (reduced_q.size() == 0) begin
        $error("unexpected item: numerator %0d denominator %0d zero %0b",
               out_item.reduced_numerator, out_item.reduced_denominator,
               out_item.zero_denominator);
        error_count++;
      end else begin
        want = reduced_q.pop_front();
        if (out_item.reduced_numerator !== want.reduced_numerator) begin
          $error("reduced_numerator: expected %0d, got %0d",
                 want.reduced_numerator, out_item.reduced_numerator);
          error_count++;
        end
        if (out_item.reduced_denominator !== want.reduced_denominator) begin
          $error("reduced_denominator: expected %0d, got %0d",
                 want.reduced_denominator, out_item.reduced_denominator);
          error_count++;
        end
        if (out_item.zero_denominator !== want.zero_denominator) begin
          $error("zero_denominator: expected %0b, got %0b",
                 want.zero_denominator, out_item.zero_denominator);
          error_count++;
        end
      end
    end
  end

  // Extremes, signs, zero numerator and zero denominator
  task automatic test_directed();
    logic [VW-1:0] maxv;
    maxv = {1'b0, {(VW-1){1'b1}}};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_fraction(0, 5);
    push_fraction(0, -7);
    push_fraction(5, 0);
    push_fraction(-5, 0);
    push_fraction(0, 0);
    push_fraction(maxv, 0);
    push_fraction(maxv, maxv);
    push_fraction(-maxv, maxv);
    push_fraction(maxv, -maxv);
    push_fraction(-maxv, -maxv);
    push_fraction(1, maxv);
    push_fraction(maxv, 1);
    push_fraction(-maxv, 1);
    push_fraction(6, 4);
    push_fraction(-6, 4);
    push_fraction(6, -4);
    push_fraction(-6, -4);
    push_fraction(12, 18);
    push_fraction(maxv, maxv - 1);
    push_fraction(1, -1);
    push_fraction(32'h4000_0000, 32'h2000_0000);
    push_fraction(-1, maxv);
    push_fraction(maxv - 1, 32'h3fff_ffff);
  endtask

  // Hold off the receiver while the sender keeps pushing
  task automatic test_full_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= ~hold_req;
    repeat (30) push_fraction(any_value(), any_value());
  endtask

  // Random fractions with shared factors, zeros and full-range values
  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    int unsigned   g, a, b;
    logic [VW-1:0] num, den;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          num = any_value();
          den = any_value();
        end
        3, 4, 5: begin
          g   = $urandom_range(65535, 1);
          a   = $urandom_range(32767);
          b   = $urandom_range(32767, 1);
          num = signed_small(g * a);
          den = signed_small(g * b);
        end
        6: begin
          num = signed_small($urandom_range(100));
          den = signed_small($urandom_range(100, 1));
        end
        7: begin
          num = 0;
          den = any_value();
        end
        8: begin
          num = any_value();
          den = 0;
        end
        default: begin
          g   = 1 << $urandom_range(20);
          num = signed_small(g * $urandom_range(1023));
          den = signed_small(g << $urandom_range(10));
        end
      endcase
      push_fraction(num, den);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_stall();
    test_random(220, 29, 52);
    test_random(220, 52, 29);
    test_random(210, 0, 0);
    in_push <= 1'b0;
    // Drain outstanding items, then let the pipeline settle
    while (reduced_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("fraction_reduce_unit test passed");
    end else begin
      $display("fraction_reduce_unit test failed");
    end
    $finish;
  end

endmodule
